@@ src/lstt_pkg.sv @@
// lstt_pkg: shared widths, defaults and controller/datapath interface types
// for the lru setter tracking table; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lstt_pkg;

  localparam int TableEntriesDef = 64;
  localparam int PidW            = 22;
  localparam int StartW          = 64;
  localparam int TickW           = 32;
  localparam int CountW          = 32;
  localparam int SlotW           = 6;
  localparam int KeyW            = PidW + StartW;
  localparam int DataW           = CountW + TickW;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic search;
    logic decide;
    logic age;
    logic update;
  } lstt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lstt_status_t;

endpackage
`default_nettype wire

@@ src/lstt_ram.sv @@
// lstt_ram: generic simple dual-port ram, one write port, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lstt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/lstt_ctrl.sv @@
// lstt_ctrl: sequencer for search, decide, aging and update of one touch
// depends on lstt_pkg
`timescale 1ns / 1ps
`default_nettype none
module lstt_ctrl
  import lstt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire lstt_status_t status_i,
  output lstt_cmd_t         cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StAge    = 3'd3;
  localparam logic [2:0] StUpdate = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = StSearch;
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        if (status_i.scan_done) state_d = StDecide;
      end
      StDecide: begin
        cmd_o.decide   = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = StAge;
      end
      StAge: begin
        cmd_o.age = 1'b1;
        if (status_i.scan_done) state_d = StUpdate;
      end
      StUpdate: begin
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule
`default_nettype wire

@@ src/lstt_dp.sv @@
// lstt_dp: table rams, valid bits, scan pipeline, victim/free/hit tracking,
// rank aging and output register; depends on lstt_pkg and lstt_ram
`timescale 1ns / 1ps
`default_nettype none
module lstt_dp
  import lstt_pkg::*;
#(
  parameter int TableEntries = TableEntriesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lstt_cmd_t         cmd_i,
  output lstt_status_t           status_o,
  input  wire logic [PidW-1:0]   key_pid_i,
  input  wire logic [StartW-1:0] key_start_i,
  input  wire logic [TickW-1:0]  now_tick_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   hit_o,
  output logic [SlotW-1:0]       slot_o,
  output logic                   evicted_o,
  output logic [PidW-1:0]        evicted_pid_o,
  output logic [CountW-1:0]      touch_count_o,
  output logic [TickW-1:0]       first_seen_o
);

  localparam int IW = $clog2(TableEntries);
  localparam int CW = $clog2(TableEntries + 1);
  localparam logic [CW-1:0] NumEntries = CW'(TableEntries);

  logic [TableEntries-1:0] valid_q;
  logic [CW-1:0]           used_q, idx_q;
  logic [IW-1:0]           j_q;
  logic                    srch_pv_q, age_pv_q;

  logic [PidW-1:0]   pid_q;
  logic [StartW-1:0] start_q;
  logic [TickW-1:0]  now_q;

  logic [KeyW-1:0]  key_rd;
  logic [DataW-1:0] data_rd;
  logic [IW-1:0]    age_rd;

  logic              hit_found_q, vic_found_q, free_found_q;
  logic [IW-1:0]     hit_slot_q, hit_rank_q, vic_slot_q, vic_rank_q, free_slot_q;
  logic [CountW-1:0] hit_count_q;
  logic [TickW-1:0]  hit_first_q;
  logic [PidW-1:0]   vic_pid_q;

  logic          is_hit_q, evict_q, age_all_q;
  logic [IW-1:0] tgt_slot_q, lim_q;

  logic              full, vj, match;
  logic              age_we;
  logic [IW-1:0]     age_waddr, age_wdata;
  logic [CountW-1:0] cnt_new, cnt_out;
  logic [TickW-1:0]  first_out;
  logic [IW+SlotW-1:0] slot_ext;

  assign full  = (used_q == NumEntries);
  assign vj    = valid_q[j_q];
  assign match = vj && (key_rd == {pid_q, start_q});

  assign status_o.scan_done = (idx_q == NumEntries);
  assign status_o.out_free  = !out_valid_o || !out_stall_i;

  // scan counter and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      srch_pv_q <= 1'b0;
      age_pv_q  <= 1'b0;
    end else begin
      srch_pv_q <= cmd_i.search && (idx_q != NumEntries);
      age_pv_q  <= cmd_i.age && (idx_q != NumEntries);
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
      end else if ((cmd_i.search || cmd_i.age) && (idx_q != NumEntries)) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= idx_q[IW-1:0];
  end

  // latched touch and search results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_found_q  <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (srch_pv_q) begin
      if (match) hit_found_q <= 1'b1;
      if (vj) vic_found_q <= 1'b1;
      if (!vj) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pid_q   <= key_pid_i;
      start_q <= key_start_i;
      now_q   <= now_tick_i;
    end
    if (srch_pv_q) begin
      if (match && !hit_found_q) begin
        hit_slot_q  <= j_q;
        hit_rank_q  <= age_rd;
        hit_count_q <= data_rd[DataW-1:TickW];
        hit_first_q <= data_rd[TickW-1:0];
      end
      if (vj && (!vic_found_q || (age_rd > vic_rank_q))) begin
        vic_slot_q <= j_q;
        vic_rank_q <= age_rd;
        vic_pid_q  <= key_rd[KeyW-1:StartW];
      end
      if (!vj && !free_found_q) begin
        free_slot_q <= j_q;
      end
    end
    if (cmd_i.decide) begin
      is_hit_q <= hit_found_q;
      if (hit_found_q) begin
        tgt_slot_q <= hit_slot_q;
        lim_q      <= hit_rank_q;
        evict_q    <= 1'b0;
        age_all_q  <= 1'b0;
      end else if (full) begin
        tgt_slot_q <= vic_slot_q;
        lim_q      <= vic_rank_q;
        evict_q    <= 1'b1;
        age_all_q  <= 1'b0;
      end else begin
        tgt_slot_q <= free_slot_q;
        lim_q      <= vic_rank_q;
        evict_q    <= 1'b0;
        age_all_q  <= 1'b1;
      end
    end
  end

  // valid bits and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else if (cmd_i.update && !is_hit_q) begin
      valid_q[tgt_slot_q] <= 1'b1;
      if (!full) used_q <= used_q + CW'(1);
    end
  end

  // rank write port: reset on update, aging otherwise
  always_comb begin
    age_we    = 1'b0;
    age_waddr = j_q;
    age_wdata = age_rd + IW'(1);
    if (cmd_i.update) begin
      age_we    = 1'b1;
      age_waddr = tgt_slot_q;
      age_wdata = '0;
    end else if (age_pv_q && vj && (age_all_q || (age_rd < lim_q))) begin
      age_we = 1'b1;
    end
  end

  assign cnt_new   = (hit_count_q == '1) ? hit_count_q : hit_count_q + CountW'(1);
  assign cnt_out   = is_hit_q ? cnt_new : CountW'(1);
  assign first_out = is_hit_q ? hit_first_q : now_q;
  assign slot_ext  = {{SlotW{1'b0}}, tgt_slot_q};

  lstt_ram #(.Width(KeyW), .Depth(TableEntries)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update && !is_hit_q),
    .waddr_i (tgt_slot_q),
    .wdata_i ({pid_q, start_q}),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (key_rd)
  );

  lstt_ram #(.Width(DataW), .Depth(TableEntries)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (tgt_slot_q),
    .wdata_i ({cnt_out, first_out}),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (data_rd)
  );

  lstt_ram #(.Width(IW), .Depth(TableEntries)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (age_waddr),
    .wdata_i (age_wdata),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (age_rd)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o         <= is_hit_q;
      slot_o        <= slot_ext[SlotW-1:0];
      evicted_o     <= evict_q;
      evicted_pid_o <= evict_q ? vic_pid_q : '0;
      touch_count_o <= cnt_out;
      first_seen_o  <= first_out;
    end
  end

endmodule
`default_nettype wire

@@ src/lru_setter_tracking_table.sv @@
// lru_setter_tracking_table: lru table of agents keyed by pid and start time
// each touch runs load, a key/rank search scan, decide, a rank aging scan and
// an update into the output register, which waits while the output is stalled;
// no new touch is taken before the update; each scan uses one ram read port
// reset: valid bits and fill count cleared at once, rams are not cleared
// depends on lstt_pkg, lstt_ctrl, lstt_dp, lstt_ram
`timescale 1ns / 1ps
`default_nettype none
module lru_setter_tracking_table
  import lstt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PidW-1:0]   key_pid_i,
  input  wire logic [StartW-1:0] key_start_i,
  input  wire logic [TickW-1:0]  now_tick_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   hit_o,
  output logic [SlotW-1:0]       slot_o,
  output logic                   evicted_o,
  output logic [PidW-1:0]        evicted_pid_o,
  output logic [CountW-1:0]      touch_count_o,
  output logic [TickW-1:0]       first_seen_o
);

  lstt_cmd_t    cmd;
  lstt_status_t status;

  lstt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lstt_dp #(.TableEntries(TABLE_ENTRIES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .key_pid_i     (key_pid_i),
    .key_start_i   (key_start_i),
    .now_tick_i    (now_tick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .slot_o        (slot_o),
    .evicted_o     (evicted_o),
    .evicted_pid_o (evicted_pid_o),
    .touch_count_o (touch_count_o),
    .first_seen_o  (first_seen_o)
  );

endmodule
`default_nettype wire
